@@ hdl/ihex_pkg.sv @@
// Package with the types, codes and helper function of the hex record parser.
package ihex_pkg;

	// Default width of the internal line counter.
	localparam int LINE_COUNT_BITS_DEF = 16;

	// Width of the line number reported with each result.
	localparam int LINE_OUT_BITS = 16;

	// Characters that the parser recognises.
	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_LOW_A   = 8'h61;
	localparam logic [7:0] CHAR_LOW_F   = 8'h66;
	localparam logic [7:0] CASE_BIT     = 8'h20;

	// Record types that the parser accepts.
	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;

	// Parse phases within one line.
	typedef enum logic [3:0] {
		PH_START = 4'd0,
		PH_LEN   = 4'd1,
		PH_ADDR  = 4'd2,
		PH_TYPE  = 4'd3,
		PH_DATA  = 4'd4,
		PH_CKSUM = 4'd5,
		PH_SKIP  = 4'd6
	} phase_t;

	// Kinds of result.
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_OK   = 2'd1,
		KIND_EOF  = 2'd2,
		KIND_ERR  = 2'd3
	} kind_t;

	// Error codes carried with an error result.
	typedef enum logic [2:0] {
		ERR_NO_COLON   = 3'd0,
		ERR_HEADER_HEX = 3'd1,
		ERR_DATA_HEX   = 3'd2,
		ERR_CKSUM_HEX  = 3'd3,
		ERR_MISMATCH   = 3'd4,
		ERR_EMPTY      = 3'd5,
		ERR_BAD_TYPE   = 3'd6,
		ERR_NONE       = 3'd7
	} err_t;

	// A decoded hex digit and whether the character was one.
	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	// Decodes one ASCII character as a hex digit of either case.
	function automatic hex_t hex_decode(input logic [7:0] c);
		logic [7:0] lc;
		logic [7:0] off;
		hex_t       h;
		lc = c | CASE_BIT;
		h.ok    = 1'b0;
		h.value = 4'd0;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			off     = c - CHAR_ZERO;
			h.ok    = 1'b1;
			h.value = off[3:0];
		end else if (lc >= CHAR_LOW_A && lc <= CHAR_LOW_F) begin
			off     = lc - CHAR_LOW_A + 8'd10;
			h.ok    = 1'b1;
			h.value = off[3:0];
		end
		return h;
	endfunction

endpackage

@@ hdl/intel_hex_record_parser.sv @@
// Intel HEX record parser: one character in, at most one result out per character.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-------------------------------------------------
//  input   | in_valid / in_ready    | text_char
//  output  | out_valid / out_ready  | kind, byte_address, byte_value, error_code,
//          |                        | line_number
//
// Each character is held in an input register and then parsed combinationally into the
// result register, so one character is taken per cycle unless a stall holds it; a character
// passes the input register and then the result register before its result is offered.
// A result waiting in the output register stalls parsing; the input register still
// holds one further character during such a stall.
// The asynchronous reset returns the parser to line start with all counts cleared.
// After any error the parser halts and drops every further character until reset.
module intel_hex_record_parser
	import ihex_pkg::*;
#(
	parameter int LINE_COUNT_BITS = LINE_COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               text_char,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               kind,
	output logic [15:0]              byte_address,
	output logic [7:0]               byte_value,
	output logic [2:0]               error_code,
	output logic [LINE_OUT_BITS-1:0] line_number
);

	localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = '1;
	localparam int LINE_EXT_BITS = LINE_COUNT_BITS + LINE_OUT_BITS;
	localparam logic [LINE_EXT_BITS-1:0] LINE_OUT_MAX =
		LINE_EXT_BITS'({LINE_OUT_BITS{1'b1}});

	// Input register.
	logic       valid_s1;
	logic [7:0] char_s1;

	// Parser state.
	phase_t                     phase_q, phase_n;
	logic [2:0]                 digits_q, digits_n;
	logic [7:0]                 length_q, length_n;
	logic [15:0]                address_q, address_n;
	logic [7:0]                 type_q, type_n;
	logic [7:0]                 sum_q, sum_n;
	logic [3:0]                 nibble_q, nibble_n;
	logic [7:0]                 done_q, done_n;
	logic [LINE_COUNT_BITS-1:0] lines_q, lines_n;
	logic                       halted_q, halted_n;

	// Result register.
	logic                     out_valid_q;
	kind_t                    kind_q;
	logic [15:0]              addr_q;
	logic [7:0]               value_q;
	logic [2:0]               err_q;
	logic [LINE_OUT_BITS-1:0] line_q;

	// Result of the character being parsed.
	logic                     res_v;
	kind_t                    res_kind;
	logic [15:0]              res_addr;
	logic [7:0]               res_val;
	err_t                     res_err;
	logic [LINE_EXT_BITS-1:0] lines_ext;
	logic [LINE_OUT_BITS-1:0] res_line;

	logic       proc;
	hex_t       hex;
	logic [7:0] byte_new;
	logic [7:0] ck_sum;
	logic [7:0] done_inc;

	// A character is parsed once the result register is free to take its result.
	assign proc     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || proc;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= text_char;
		end
	end

	// Parsing of one character: next state and result.
	always_comb begin
		hex       = hex_decode(char_s1);
		byte_new  = {nibble_q, hex.value};
		ck_sum    = sum_q + byte_new;
		done_inc  = done_q + 8'd1;
		phase_n   = phase_q;
		digits_n  = digits_q;
		length_n  = length_q;
		address_n = address_q;
		type_n    = type_q;
		sum_n     = sum_q;
		nibble_n  = nibble_q;
		done_n    = done_q;
		lines_n   = lines_q;
		halted_n  = halted_q;
		res_v     = 1'b0;
		res_kind  = KIND_DATA;
		res_addr  = 16'd0;
		res_val   = 8'd0;
		res_err   = ERR_NONE;
		if (proc && !halted_q) begin
			case (phase_q)
				PH_START: begin
					if (lines_q != LINE_MAX) begin
						lines_n = lines_q + 1'b1;
					end
					if (char_s1 != CHAR_COLON) begin
						res_v   = 1'b1;
						res_err = ERR_NO_COLON;
					end else begin
						phase_n   = PH_LEN;
						digits_n  = 3'd0;
						length_n  = 8'd0;
						address_n = 16'd0;
						type_n    = 8'd0;
						sum_n     = 8'd0;
						done_n    = 8'd0;
					end
				end
				PH_LEN: begin
					if (!hex.ok) begin
						res_v   = 1'b1;
						res_err = ERR_HEADER_HEX;
					end else begin
						length_n = {length_q[3:0], hex.value};
						digits_n = digits_q + 3'd1;
						if (digits_q == 3'd1) begin
							sum_n    = sum_q + length_n;
							phase_n  = PH_ADDR;
							digits_n = 3'd0;
						end
					end
				end
				PH_ADDR: begin
					if (!hex.ok) begin
						res_v   = 1'b1;
						res_err = ERR_HEADER_HEX;
					end else begin
						address_n = {address_q[11:0], hex.value};
						digits_n  = digits_q + 3'd1;
						if (digits_q == 3'd3) begin
							sum_n    = sum_q + address_n[15:8] + address_n[7:0];
							phase_n  = PH_TYPE;
							digits_n = 3'd0;
						end
					end
				end
				PH_TYPE: begin
					if (!hex.ok) begin
						res_v   = 1'b1;
						res_err = ERR_HEADER_HEX;
					end else begin
						type_n   = {type_q[3:0], hex.value};
						digits_n = digits_q + 3'd1;
						if (digits_q == 3'd1) begin
							digits_n = 3'd0;
							sum_n    = sum_q + type_n;
							if (type_n == REC_EOF) begin
								phase_n  = PH_SKIP;
								res_v    = 1'b1;
								res_kind = KIND_EOF;
							end else if (type_n != REC_DATA) begin
								res_v   = 1'b1;
								res_err = ERR_BAD_TYPE;
							end else if (length_q == 8'd0) begin
								res_v   = 1'b1;
								res_err = ERR_EMPTY;
							end else begin
								phase_n = PH_DATA;
							end
						end
					end
				end
				PH_DATA: begin
					if (!hex.ok) begin
						res_v   = 1'b1;
						res_err = ERR_DATA_HEX;
					end else if (digits_q == 3'd0) begin
						nibble_n = hex.value;
						digits_n = 3'd1;
					end else begin
						digits_n = 3'd0;
						sum_n    = ck_sum;
						done_n   = done_inc;
						if (done_inc == length_q) begin
							phase_n = PH_CKSUM;
						end
						res_v    = 1'b1;
						res_kind = KIND_DATA;
						res_addr = address_q + {8'd0, done_q};
						res_val  = byte_new;
					end
				end
				PH_CKSUM: begin
					if (!hex.ok) begin
						res_v   = 1'b1;
						res_err = ERR_CKSUM_HEX;
					end else if (digits_q == 3'd0) begin
						nibble_n = hex.value;
						digits_n = 3'd1;
					end else begin
						digits_n = 3'd0;
						if (ck_sum != 8'd0) begin
							res_v   = 1'b1;
							res_err = ERR_MISMATCH;
						end else begin
							phase_n  = PH_SKIP;
							res_v    = 1'b1;
							res_kind = KIND_OK;
						end
					end
				end
				PH_SKIP: begin
					if (char_s1 == CHAR_NEWLINE) begin
						phase_n = PH_START;
					end
				end
				default: begin
					phase_n = PH_START;
				end
			endcase
			// Every error result halts the parser.
			if (res_err != ERR_NONE) begin
				res_kind = KIND_ERR;
				halted_n = 1'b1;
			end
		end
	end

	// The reported line number saturates at the output width.
	always_comb begin
		lines_ext = {{LINE_OUT_BITS{1'b0}}, lines_n};
		if (lines_ext > LINE_OUT_MAX) begin
			res_line = '1;
		end else begin
			res_line = lines_ext[LINE_OUT_BITS-1:0];
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			digits_q  <= 3'd0;
			length_q  <= 8'd0;
			address_q <= 16'd0;
			type_q    <= 8'd0;
			sum_q     <= 8'd0;
			nibble_q  <= 4'd0;
			done_q    <= 8'd0;
			lines_q   <= '0;
			halted_q  <= 1'b0;
		end else begin
			phase_q   <= phase_n;
			digits_q  <= digits_n;
			length_q  <= length_n;
			address_q <= address_n;
			type_q    <= type_n;
			sum_q     <= sum_n;
			nibble_q  <= nibble_n;
			done_q    <= done_n;
			lines_q   <= lines_n;
			halted_q  <= halted_n;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= res_v;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (proc && res_v) begin
			kind_q  <= res_kind;
			addr_q  <= res_addr;
			value_q <= res_val;
			err_q   <= (res_kind == KIND_ERR) ? res_err : 3'd0;
			line_q  <= res_line;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign byte_address = addr_q;
	assign byte_value   = value_q;
	assign error_code   = err_q;
	assign line_number  = line_q;

endmodule

@@ hdl/ihex_checker.sv @@
// Port checker for the hex record parser, bound to its top level.
module ihex_checker
	import ihex_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [1:0]               kind,
	input logic [15:0]              byte_address,
	input logic [7:0]               byte_value,
	input logic [2:0]               error_code,
	input logic [LINE_OUT_BITS-1:0] line_number
);

	// A result that is not taken stays with its payload unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(byte_address)
			&& $stable(byte_value) && $stable(error_code) && $stable(line_number))
		else $error("stalled result changed");

	// Once an error result is delivered the parser is halted and offers nothing more.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && kind == KIND_ERR |=> !out_valid)
		else $error("result after error");

	// Address and value are zero for every result other than a data byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DATA |-> byte_address == 16'd0 && byte_value == 8'd0)
		else $error("address or value set on a non-data result");

	// An error code only accompanies an error result and is always a defined code.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_ERR || error_code == 3'd0) && error_code != ERR_NONE)
		else $error("error code out of place");

	// Every result belongs to a line already begun.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_number != '0)
		else $error("result before any line began");

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kind         (kind),
	.byte_address (byte_address),
	.byte_value   (byte_value),
	.error_code   (error_code),
	.line_number  (line_number)
);

@@ dv/tb_intel_hex_record_parser.sv @@
// Self-checking testbench for the Intel HEX record parser, with its own record predictor.
`timescale 1ns / 1ps

module tb_intel_hex_record_parser;
	import ihex_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int TOTAL_CHARS   = 860;
	localparam int HOLD_AT_CHARS = 300;
	localparam int HOLD_CYCLES   = 80;
	localparam int CALM_TAIL     = 150;
	localparam int MAX_PRINTS    = 30;

	// One parser result as the monitor sees it.
	typedef struct packed {
		kind_t       kind;
		logic [15:0] addr;
		logic [7:0]  value;
		logic [2:0]  code;
		logic [15:0] line;
	} parse_result_t;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [7:0]  text_char   = 8'h00;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [1:0]  kind;
	logic [15:0] byte_address;
	logic [7:0]  byte_value;
	logic [2:0]  error_code;
	logic [15:0] line_number;

	// Stimulus and scoreboard storage.
	logic [7:0]    char_queue[$];
	parse_result_t expected_results[$];
	int            mismatch_count = 0;
	int            chars_taken    = 0;
	int            cycle_count    = 0;
	logic          char_taken     = 1'b0;
	logic          quiet_tail     = 1'b0;
	int            hold_left      = 0;
	logic          hold_done      = 1'b0;

	// Predictor state, starting in the state that the reset leaves.
	phase_t      parse_at  = PH_START;
	logic [2:0]  digit_cnt = '0;
	logic [7:0]  rec_len   = '0;
	logic [15:0] rec_addr  = '0;
	logic [7:0]  rec_type  = '0;
	logic [7:0]  sum_acc   = '0;
	logic [3:0]  hi_nib    = '0;
	logic [7:0]  done_cnt  = '0;
	logic [15:0] line_cnt  = '0;
	logic        halted    = 1'b0;

	intel_hex_record_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_char    (text_char),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.byte_address (byte_address),
		.byte_value   (byte_value),
		.error_code   (error_code),
		.line_number  (line_number)
	);

	// Free-running clock with a 4 ns period.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Value of a hex digit of either case, or -1 for any other character.
	function automatic int nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	// ASCII digit for a nibble, with letters in a random case.
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return "0" + n;
		return (($urandom_range(0, 1) == 0) ? "a" : "A") + n - 4'd10;
	endfunction

	// A random character that no hex digit field accepts, often a newline.
	function automatic logic [7:0] pick_non_hex();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
		if ($urandom_range(0, 3) == 0) c = CHAR_NEWLINE;
		return c;
	endfunction

	task automatic log_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("MISMATCH %s: got %0h, expected %0h (t=%0t)", what, got, want, $realtime);
	endtask

	task automatic note_result(input kind_t k, input logic [15:0] a, input logic [7:0] v,
			input logic [2:0] e);
		parse_result_t r;
		r.kind  = k;
		r.addr  = a;
		r.value = v;
		r.code  = e;
		r.line  = line_cnt;
		expected_results.push_back(r);
	endtask

	task automatic stop_with(input err_t e);
		halted = 1'b1;
		note_result(KIND_ERR, '0, '0, e);
	endtask

	// Advances the predicted parser by one accepted character.
	task automatic predict_char(input logic [7:0] c);
		int         nib;
		logic [7:0] whole;
		if (halted) return;
		nib = nibble_of(c);
		case (parse_at)
		PH_START: begin
			if (line_cnt != 16'hFFFF) line_cnt++;
			if (c != CHAR_COLON) begin
				stop_with(ERR_NO_COLON);
			end else begin
				parse_at  = PH_LEN;
				digit_cnt = '0;
				rec_len   = '0;
				rec_addr  = '0;
				rec_type  = '0;
				sum_acc   = '0;
				done_cnt  = '0;
			end
		end
		PH_LEN: begin
			if (nib < 0) begin
				stop_with(ERR_HEADER_HEX);
			end else begin
				rec_len = {rec_len[3:0], nib[3:0]};
				digit_cnt++;
				if (digit_cnt == 3'd2) begin
					sum_acc   = sum_acc + rec_len;
					parse_at  = PH_ADDR;
					digit_cnt = '0;
				end
			end
		end
		PH_ADDR: begin
			if (nib < 0) begin
				stop_with(ERR_HEADER_HEX);
			end else begin
				rec_addr = {rec_addr[11:0], nib[3:0]};
				digit_cnt++;
				if (digit_cnt == 3'd4) begin
					sum_acc   = sum_acc + rec_addr[15:8] + rec_addr[7:0];
					parse_at  = PH_TYPE;
					digit_cnt = '0;
				end
			end
		end
		PH_TYPE: begin
			if (nib < 0) begin
				stop_with(ERR_HEADER_HEX);
			end else begin
				rec_type = {rec_type[3:0], nib[3:0]};
				digit_cnt++;
				if (digit_cnt == 3'd2) begin
					digit_cnt = '0;
					sum_acc   = sum_acc + rec_type;
					if (rec_type == REC_EOF) begin
						parse_at = PH_SKIP;
						note_result(KIND_EOF, '0, '0, '0);
					end else if (rec_type != REC_DATA) begin
						stop_with(ERR_BAD_TYPE);
					end else if (rec_len == 8'd0) begin
						stop_with(ERR_EMPTY);
					end else begin
						parse_at = PH_DATA;
					end
				end
			end
		end
		PH_DATA: begin
			if (nib < 0) begin
				stop_with(ERR_DATA_HEX);
			end else if (digit_cnt == 3'd0) begin
				hi_nib    = nib[3:0];
				digit_cnt = 3'd1;
			end else begin
				whole     = {hi_nib, nib[3:0]};
				digit_cnt = '0;
				note_result(KIND_DATA, rec_addr + done_cnt, whole, '0);
				sum_acc  = sum_acc + whole;
				done_cnt = done_cnt + 8'd1;
				if (done_cnt == rec_len) parse_at = PH_CKSUM;
			end
		end
		PH_CKSUM: begin
			if (nib < 0) begin
				stop_with(ERR_CKSUM_HEX);
			end else if (digit_cnt == 3'd0) begin
				hi_nib    = nib[3:0];
				digit_cnt = 3'd1;
			end else begin
				whole     = sum_acc + {hi_nib, nib[3:0]};
				digit_cnt = '0;
				if (whole != 8'd0) begin
					stop_with(ERR_MISMATCH);
				end else begin
					parse_at = PH_SKIP;
					note_result(KIND_OK, '0, '0, '0);
				end
			end
		end
		PH_SKIP: begin
			if (c == CHAR_NEWLINE) parse_at = PH_START;
		end
		default: parse_at = PH_START;
		endcase
	endtask

	// Stimulus building blocks.
	task automatic push_hex(input logic [7:0] b);
		char_queue.push_back(hex_char(b[7:4]));
		char_queue.push_back(hex_char(b[3:0]));
	endtask

	// Ends a line, sometimes after junk of any value but newline.
	task automatic push_line_end();
		logic [7:0] c;
		int         n;
		n = $urandom_range(0, 3);
		if ($urandom_range(0, 1) == 0) char_queue.push_back(8'h0D);
		repeat (n) begin
			do c = 8'($urandom_range(0, 255)); while (c == CHAR_NEWLINE);
			char_queue.push_back(c);
		end
		char_queue.push_back(CHAR_NEWLINE);
	endtask

	// A whole record line; a non-zero skew spoils the checksum.
	task automatic add_record(input logic [7:0] rtype, input logic [15:0] addr,
			input logic [7:0] payload[$], input logic [7:0] skew);
		logic [7:0] sum;
		sum = 8'(payload.size()) + addr[15:8] + addr[7:0] + rtype;
		char_queue.push_back(CHAR_COLON);
		push_hex(8'(payload.size()));
		push_hex(addr[15:8]);
		push_hex(addr[7:0]);
		push_hex(rtype);
		foreach (payload[i]) begin
			push_hex(payload[i]);
			sum = sum + payload[i];
		end
		push_hex(8'd0 - sum + skew);
		push_line_end();
	endtask

	// One line that ends the parse with a randomly chosen error.
	task automatic add_fatal_line();
		logic [7:0] payload[$];
		logic [7:0] c;
		int         mark;
		int         n;
		int         keep;
		mark = char_queue.size();
		n    = $urandom_range(1, 4);
		repeat (n) payload.push_back(8'($urandom_range(0, 255)));
		case ($urandom_range(0, 6))
		0: begin
			do c = 8'($urandom_range(0, 255)); while (c == CHAR_COLON);
			if ($urandom_range(0, 3) == 0) c = CHAR_NEWLINE;
			char_queue.push_back(c);
			add_record(REC_DATA, 16'($urandom), payload, 8'd0);
		end
		1: begin
			add_record(REC_DATA, 16'($urandom), payload, 8'd0);
			keep       = mark + $urandom_range(1, 8);
			char_queue = char_queue[0:keep-1];
			char_queue.push_back(pick_non_hex());
		end
		2: begin
			add_record(REC_DATA, 16'($urandom), payload, 8'd0);
			keep       = mark + 9 + $urandom_range(0, 2 * n - 1);
			char_queue = char_queue[0:keep-1];
			char_queue.push_back(pick_non_hex());
		end
		3: begin
			add_record(REC_DATA, 16'($urandom), payload, 8'd0);
			keep       = mark + 9 + 2 * n + $urandom_range(0, 1);
			char_queue = char_queue[0:keep-1];
			char_queue.push_back(pick_non_hex());
		end
		4: add_record(REC_DATA, 16'($urandom), payload, 8'($urandom_range(1, 255)));
		5: begin
			payload.delete();
			add_record(REC_DATA, 16'($urandom), payload, 8'd0);
		end
		default: add_record(8'($urandom_range(2, 255)), 16'($urandom), payload, 8'd0);
		endcase
	endtask

	// Fills the stimulus, releases reset and waits for the run to drain.
	initial begin
		logic [7:0] payload[$];
		int         target;
		int         roll;
		int         n;

		// Directed records: extreme addresses, bytes and lengths.
		payload = '{8'h00};
		add_record(REC_DATA, 16'h0000, payload, 8'd0);
		payload = '{8'hFF, 8'h00, 8'hA5, 8'h5A};
		add_record(REC_DATA, 16'hFFFE, payload, 8'd0);
		payload = '{8'hAB, 8'hCD};
		add_record(REC_EOF, 16'hFFFF, payload, 8'd7);
		payload.delete();
		add_record(REC_EOF, 16'h0000, payload, 8'd0);
		for (int i = 0; i < 255; i++) payload.push_back(i[7:0]);
		add_record(REC_DATA, 16'hFF80, payload, 8'd0);
		payload = '{8'hFF, 8'hFF, 8'hFF};
		add_record(REC_DATA, 16'h8000, payload, 8'd0);
		// Skipped tail with high-bit characters after an end-of-file record.
		payload.delete();
		add_record(REC_EOF, 16'h1234, payload, 8'd0);
		char_queue.pop_back();
		char_queue.push_back(8'h80);
		char_queue.push_back(8'hFF);
		char_queue.push_back(8'h7F);
		char_queue.push_back(CHAR_NEWLINE);

		// Random records that parse without error up to the run length, a few very long ones.
		target = TOTAL_CHARS;
		while (char_queue.size() < target) begin
			payload.delete();
			roll = $urandom_range(0, 99);
			if (roll < 82) begin
				n = ($urandom_range(0, 59) == 0) ? $urandom_range(200, 255) : $urandom_range(1, 16);
				repeat (n) payload.push_back(8'($urandom_range(0, 255)));
				add_record(REC_DATA, 16'($urandom), payload, 8'd0);
			end else begin
				n = $urandom_range(0, 3);
				repeat (n) payload.push_back(8'($urandom_range(0, 255)));
				add_record(REC_EOF, 16'($urandom), payload, 8'($urandom_range(0, 1)));
			end
		end

		// One error, then characters that the halted parser must drop.
		add_fatal_line();
		repeat (20) char_queue.push_back(8'($urandom_range(0, 255)));

		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		while (char_queue.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("tb_intel_hex_record_parser passed");
		end else begin
			$display("tb_intel_hex_record_parser failed");
		end
		$finish;
	end

	// Request driver: offers queued characters with random idle bursts.
	always @(negedge clk) begin : drive_requests
		logic       next_valid;
		logic [7:0] next_char;
		int         send_gap;
		int         send_stretch;
		logic       send_noisy;
		next_valid = in_valid;
		next_char  = text_char;
		if (arst_n && (!in_valid || char_taken)) begin
			next_valid = 1'b0;
			if (send_stretch <= 0) begin
				send_stretch = $urandom_range(20, 80);
				send_noisy   = ($urandom_range(0, 2) != 0);
			end
			if (send_gap > 0) begin
				send_gap--;
			end else if (char_queue.size() != 0) begin
				if (!quiet_tail && send_noisy && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(1, 5) - 1;
				end else begin
					next_valid = 1'b1;
					next_char  = char_queue.pop_front();
					send_stretch--;
				end
			end
		end
		in_valid  <= next_valid;
		text_char <= next_char;
	end

	// Result receiver: random back-pressure bursts plus the long hold.
	always @(negedge clk) begin : drive_ready
		logic next_ready;
		int   recv_gap;
		int   recv_stretch;
		logic recv_noisy;
		next_ready = 1'b1;
		if (recv_stretch <= 0) begin
			recv_stretch = $urandom_range(20, 100);
			recv_noisy   = ($urandom_range(0, 2) != 0);
		end
		recv_stretch--;
		if (hold_left != 0) begin
			next_ready = 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			next_ready = 1'b0;
		end else if (!quiet_tail && recv_noisy && $urandom_range(0, 5) == 0) begin
			recv_gap   = $urandom_range(1, 5) - 1;
			next_ready = 1'b0;
		end
		out_ready <= next_ready;
	end

	// Long receiver hold once the run is under way, so the parser backs up.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && chars_taken >= HOLD_AT_CHARS) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
		quiet_tail <= (char_queue.size() < CALM_TAIL);
	end

	// Monitor: checks each accepted result and predicts from each accepted request.
	always @(posedge clk) begin : check_results
		parse_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					log_mismatch("result with nothing expected, kind", 32'(kind), '0);
				end else begin
					want = expected_results.pop_front();
					if (kind !== want.kind)
						log_mismatch("kind", 32'(kind), 32'(want.kind));
					if (byte_address !== want.addr)
						log_mismatch("byte_address", 32'(byte_address), 32'(want.addr));
					if (byte_value !== want.value)
						log_mismatch("byte_value", 32'(byte_value), 32'(want.value));
					if (error_code !== want.code)
						log_mismatch("error_code", 32'(error_code), 32'(want.code));
					if (line_number !== want.line)
						log_mismatch("line_number", 32'(line_number), 32'(want.line));
				end
			end
			if (in_valid && in_ready) begin
				predict_char(text_char);
				chars_taken <= chars_taken + 1;
			end
			char_taken <= in_valid && in_ready;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_intel_hex_record_parser failed");
			$finish;
		end
	end

endmodule

@@ filelist.f @@
hdl/ihex_pkg.sv
hdl/intel_hex_record_parser.sv
hdl/ihex_checker.sv
dv/tb_intel_hex_record_parser.sv
